// ===== rtl/plrt_pkg.sv =====
// shared types and constants of the piecewise-linear rgba transfer lut
// no dependencies; imported by every module of the block

package plrt_pkg;

	localparam int MAX_POINTS    = 16;
	localparam int TABLE_ENTRIES = 255;
	localparam int IDX_W         = $clog2(MAX_POINTS);
	localparam int CNT_W         = $clog2(MAX_POINTS + 1);
	localparam int DIV_STEPS     = 8;
	localparam int STEP_W        = $clog2(DIV_STEPS);
	localparam logic [7:0] END_KEY = 8'd255;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_NONE   = 2'd3
	} kind_e;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_DUP   = 2'd2,
		ST_RANGE = 2'd3
	} status_e;

	typedef struct packed {
		logic [7:0]      key;
		logic [3:0][7:0] ch;
	} point_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    clear;
		logic    rd_ptr;
		logic    ptr_inc;
		logic    shift_init;
		logic    shift_rd;
		logic    shift_wr;
		logic    ins_write;
		logic    take_lo;
		logic    take_hi;
		logic    mul;
		logic    div_step;
		logic    st_we;
		status_e st_code;
		logic    res_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic             at_end;
		logic             key_lt;
		logic             key_eq;
		logic             key_le;
		logic             full;
		logic             shift_done;
		logic             div_done;
		logic             out_free;
		logic             in_oor;
		logic [CNT_W-1:0] count;
	} sts_t;

endpackage

// ===== rtl/piecewise_linear_rgba_transfer_lut_top.sv =====
// Piecewise-linear RGBA transfer lut: keeps up to 16 control points sorted by key in a
// point memory with one read and one write port and answers insert, clear and lookup
// transactions one at a time, each giving one result. An insert walks the memory one
// entry at a time to find the slot, then moves the entries above it up one at a time;
// a duplicate or full insert ends after the walk. A lookup walks the stored points
// until the segment is found, then takes a multiply step, then four restoring
// dividers, one per channel, run side by side for 8 steps. The next transaction is
// accepted while a result waits on the output. No clearing pass is needed after reset.

module piecewise_linear_rgba_transfer_lut_top import plrt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] key_index,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [7:0] alpha_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic [7:0] alpha_out,
	output logic [1:0] status
);

	cmd_t cmd;
	sts_t sts;

	plrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	plrt_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (kind),
		.key_index  (key_index),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.alpha_in   (alpha_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.alpha_out  (alpha_out),
		.status     (status)
	);

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= CNT_W'(MAX_POINTS))
		else $error("point count above capacity");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.shift_wr && !cmd.ins_write && !cmd.res_load)
		else $error("memory or result written while idle");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_CLEAR |=> sts.count == '0)
		else $error("clear left points in store");

	a_reject_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_DUP) |->
		red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0 && alpha_out == 8'd0)
		else $error("rejected insert carries color");
`endif

endmodule

// ===== rtl/plrt_ctrl.sv =====
// controller state machine of the transfer lut: sequences insert, clear and lookup
// depends on plrt_pkg for the command and status structs

module plrt_ctrl import plrt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_ISRD = 11'b00000000010,
		S_ISCM = 11'b00000000100,
		S_IDEC = 11'b00000001000,
		S_SHRD = 11'b00000010000,
		S_SHWR = 11'b00000100000,
		S_IWR  = 11'b00001000000,
		S_LSRD = 11'b00010000000,
		S_LSCM = 11'b00100000000,
		S_LMUL = 11'b01000000000,
		S_LDIV = 11'b10000000000
	} state_e;

	state_e state_q, state_d;
	logic   fin_q, fin_d;

	assign in_ready = (state_q == S_IDLE) && !fin_q;

	always_comb begin
		state_d = state_q;
		fin_d   = fin_q;
		cmd     = '0;
		cmd.st_code = ST_OK;
		if (fin_q) begin
			// result waits here until the output register is free
			if (sts.out_free) begin
				cmd.res_load = 1'b1;
				fin_d = 1'b0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd.load = 1'b1;
						case (kind_e'(kind))
							KIND_INSERT: state_d = S_ISRD;
							KIND_CLEAR: begin
								cmd.clear = 1'b1;
								fin_d = 1'b1;
							end
							KIND_LOOKUP: begin
								if (sts.in_oor)
									fin_d = 1'b1;
								else
									state_d = S_LSRD;
							end
							default: fin_d = 1'b1;
						endcase
					end
				end
				S_ISRD: begin
					if (sts.at_end) begin
						state_d = S_IDEC;
					end else begin
						cmd.rd_ptr = 1'b1;
						state_d = S_ISCM;
					end
				end
				S_ISCM: begin
					if (sts.key_lt) begin
						cmd.ptr_inc = 1'b1;
						state_d = S_ISRD;
					end else if (sts.key_eq) begin
						cmd.st_we   = 1'b1;
						cmd.st_code = ST_DUP;
						state_d = S_IDLE;
						fin_d = 1'b1;
					end else begin
						state_d = S_IDEC;
					end
				end
				S_IDEC: begin
					if (sts.full) begin
						cmd.st_we   = 1'b1;
						cmd.st_code = ST_FULL;
						state_d = S_IDLE;
						fin_d = 1'b1;
					end else begin
						cmd.shift_init = 1'b1;
						state_d = S_SHRD;
					end
				end
				S_SHRD: begin
					if (sts.shift_done) begin
						state_d = S_IWR;
					end else begin
						cmd.shift_rd = 1'b1;
						state_d = S_SHWR;
					end
				end
				S_SHWR: begin
					cmd.shift_wr = 1'b1;
					state_d = S_SHRD;
				end
				S_IWR: begin
					cmd.ins_write = 1'b1;
					state_d = S_IDLE;
					fin_d = 1'b1;
				end
				S_LSRD: begin
					if (sts.at_end) begin
						state_d = S_LMUL;
					end else begin
						cmd.rd_ptr = 1'b1;
						state_d = S_LSCM;
					end
				end
				S_LSCM: begin
					if (sts.key_le) begin
						cmd.take_lo = 1'b1;
						state_d = S_LSRD;
					end else begin
						cmd.take_hi = 1'b1;
						state_d = S_LMUL;
					end
				end
				S_LMUL: begin
					cmd.mul = 1'b1;
					state_d = S_LDIV;
				end
				S_LDIV: begin
					cmd.div_step = 1'b1;
					if (sts.div_done) begin
						state_d = S_IDLE;
						fin_d = 1'b1;
					end
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
		end
	end

endmodule

// ===== rtl/plrt_dpath.sv =====
// datapath of the transfer lut: point memory, search pointers, interpolation
// multipliers, bit-serial dividers and output register; depends on plrt_pkg

module plrt_dpath import plrt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  logic [1:0] kind,
	input  logic [7:0] key_index,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [7:0] alpha_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic [7:0] alpha_out,
	output logic [1:0] status
);

	point_t           mem [MAX_POINTS];
	point_t           rdata_q;
	point_t           new_q;
	point_t           lo_q, hi_q;
	logic [CNT_W-1:0] cnt_q, ptr_q, j_q, jm1;
	logic [7:0]       d_q;
	logic [3:0][15:0] work_q, work_d, num_d;
	logic [STEP_W-1:0] step_q;
	status_e          status_q;
	logic             lookup_q;
	logic             out_valid_q;
	logic [3:0][7:0]  col_out_q;
	logic [1:0]       status_out_q;
	logic             in_oor;
	logic [7:0]       d_raw, k_raw, d_c, k_c;

	assign in_oor = ({1'b0, key_index} >= 9'(TABLE_ENTRIES));
	assign jm1    = j_q - CNT_W'(1);

	assign sts.at_end     = (ptr_q == cnt_q);
	assign sts.key_lt     = (rdata_q.key < new_q.key);
	assign sts.key_eq     = (rdata_q.key == new_q.key);
	assign sts.key_le     = (rdata_q.key <= new_q.key);
	assign sts.full       = (cnt_q == CNT_W'(MAX_POINTS));
	assign sts.shift_done = (j_q == ptr_q);
	assign sts.div_done   = (step_q == STEP_W'(DIV_STEPS - 1));
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.in_oor     = in_oor;
	assign sts.count      = cnt_q;

	// point memory, one read and one write port
	always_ff @(posedge clk) begin
		if (cmd.rd_ptr)
			rdata_q <= mem[ptr_q[IDX_W-1:0]];
		else if (cmd.shift_rd)
			rdata_q <= mem[jm1[IDX_W-1:0]];
		if (cmd.shift_wr)
			mem[j_q[IDX_W-1:0]] <= rdata_q;
		else if (cmd.ins_write)
			mem[ptr_q[IDX_W-1:0]] <= new_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ptr_q  <= '0;
			j_q    <= '0;
			step_q <= '0;
		end else begin
			if (cmd.clear)
				cnt_q <= '0;
			else if (cmd.ins_write)
				cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.load)
				ptr_q <= '0;
			else if (cmd.ptr_inc || cmd.take_lo)
				ptr_q <= ptr_q + CNT_W'(1);
			if (cmd.shift_init)
				j_q <= cnt_q;
			else if (cmd.shift_wr)
				j_q <= jm1;
			if (cmd.mul)
				step_q <= '0;
			else if (cmd.div_step)
				step_q <= step_q + STEP_W'(1);
		end
	end

	// segment width and offset; a zero width cannot arise but is guarded
	always_comb begin
		d_raw = hi_q.key - lo_q.key;
		k_raw = new_q.key - lo_q.key;
		if (d_raw == 8'd0) begin
			d_c = 8'd1;
			k_c = 8'd0;
		end else begin
			d_c = d_raw;
			k_c = k_raw;
		end
	end

	always_comb begin
		logic [8:0] t;
		logic       ge;
		logic [7:0] up;
		for (int c = 0; c < 4; c++) begin
			num_d[c] = 16'(lo_q.ch[c]) * 16'(d_c - k_c) + 16'(hi_q.ch[c]) * 16'(k_c);
			// restoring step: upper byte of the work word stays below the divisor
			t  = {work_q[c][15:8], work_q[c][7]};
			ge = (t >= {1'b0, d_q});
			up = ge ? 8'(t - {1'b0, d_q}) : t[7:0];
			work_d[c] = {up, work_q[c][6:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_q    <= '{key: key_index, ch: {alpha_in, blue_in, green_in, red_in}};
			lo_q     <= '0;
			hi_q     <= '{key: END_KEY, ch: '0};
			lookup_q <= (kind_e'(kind) == KIND_LOOKUP) && !in_oor;
			status_q <= ((kind_e'(kind) == KIND_LOOKUP) && in_oor) ? ST_RANGE : ST_OK;
		end else begin
			if (cmd.take_lo)
				lo_q <= rdata_q;
			if (cmd.take_hi)
				hi_q <= rdata_q;
			if (cmd.st_we)
				status_q <= cmd.st_code;
		end
		if (cmd.mul) begin
			work_q <= num_d;
			d_q    <= d_c;
		end else if (cmd.div_step) begin
			work_q <= work_d;
		end
		if (cmd.res_load) begin
			for (int c = 0; c < 4; c++)
				col_out_q[c] <= lookup_q ? work_q[c][7:0] : 8'd0;
			status_out_q <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.res_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign red_out   = col_out_q[0];
	assign green_out = col_out_q[1];
	assign blue_out  = col_out_q[2];
	assign alpha_out = col_out_q[3];
	assign status    = status_out_q;

endmodule

// ===== sim/plrt_transfer_checker.sv =====
// scoreboard for the piecewise-linear rgba transfer lut: watches both channels,
// keeps its own copy of the sorted point store and compares every result in order
// depends on plrt_pkg for the kind and status codes and the point layout

module plrt_transfer_checker import plrt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] key_index,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [7:0] alpha_in,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] red_out,
	input  logic [7:0] green_out,
	input  logic [7:0] blue_out,
	input  logic [7:0] alpha_out,
	input  logic [1:0] status,
	output int         fail_count,
	output int         outstanding,
	output int         results_checked,
	output int         flagged_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0][7:0] color;
		status_e         code;
	} lut_result_t;

	point_t      point_mem [MAX_POINTS];
	int unsigned point_total;
	lut_result_t pending_colors [$];
	int          fails = 0;
	int          checked = 0;
	int          flagged = 0;

	function automatic lut_result_t predict_lut_result(kind_e op, logic [7:0] value,
			logic [3:0][7:0] color);
		lut_result_t     res;
		int unsigned     pos, lo_key, hi_key, span, offset, mix;
		logic [3:0][7:0] lo_c, hi_c;
		bit              found;
		res = '0;
		case (op)
			KIND_INSERT: begin
				pos = 0;
				while (pos < point_total && point_mem[pos].key < value)
					pos++;
				// duplicate wins over full
				if (pos < point_total && point_mem[pos].key == value)
					res.code = ST_DUP;
				else if (point_total >= MAX_POINTS)
					res.code = ST_FULL;
				else begin
					for (int j = point_total; j > pos; j--)
						point_mem[j] = point_mem[j - 1];
					point_mem[pos] = '{key: value, ch: color};
					point_total++;
				end
			end
			KIND_CLEAR: point_total = 0;
			KIND_LOOKUP: begin
				if (value >= TABLE_ENTRIES)
					res.code = ST_RANGE;
				else begin
					// ramp from transparent black at 0 and to it at 255
					lo_key = 0;
					hi_key = END_KEY;
					lo_c = '0;
					hi_c = '0;
					found = 1'b0;
					for (int i = 0; i < point_total && !found; i++) begin
						if (point_mem[i].key <= value) begin
							lo_key = point_mem[i].key;
							lo_c = point_mem[i].ch;
						end else begin
							hi_key = point_mem[i].key;
							hi_c = point_mem[i].ch;
							found = 1'b1;
						end
					end
					span = hi_key - lo_key;
					offset = value - lo_key;
					for (int c = 0; c < 4; c++) begin
						mix = (lo_c[c] * (span - offset) + hi_c[c] * offset) / span;
						res.color[c] = mix[7:0];
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lut_result_t want;
		if (!arst_n) begin
			point_total = 0;
			pending_colors.delete();
			outstanding <= 0;
			fail_count <= 0;
			results_checked <= 0;
			flagged_results <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_colors.size() == 0) begin
					$error("result transaction with nothing expected");
					fails++;
				end else begin
					want = pending_colors.pop_front();
					check_field("red_out", want.color[0], red_out);
					check_field("green_out", want.color[1], green_out);
					check_field("blue_out", want.color[2], blue_out);
					check_field("alpha_out", want.color[3], alpha_out);
					check_field("status", 8'(want.code), 8'(status));
					checked++;
					if (want.code != ST_OK)
						flagged++;
				end
			end
			if (in_valid && in_ready)
				pending_colors.push_back(predict_lut_result(kind_e'(kind), key_index,
					{alpha_in, blue_in, green_in, red_in}));
			// registered so the stimulus side reads a settled value after each edge
			outstanding <= pending_colors.size();
			fail_count <= fails;
			results_checked <= checked;
			flagged_results <= flagged;
		end
	end

endmodule

// ===== sim/tb_piecewise_linear_rgba_transfer_lut_top.sv =====
// testbench top for the piecewise-linear rgba transfer lut: drives insert, clear and
// lookup transactions with random gaps and output stalls and gives the verdict
// depends on plrt_pkg, the rtl top and plrt_transfer_checker

module tb_piecewise_linear_rgba_transfer_lut_top;
	timeunit 1ns;
	timeprecision 1ps;
	import plrt_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int IDLE_LIMIT   = 4000;
	localparam int TAIL_CYCLES  = 100;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] kind;
	logic [7:0] key_index;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [7:0] alpha_in;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;
	logic [1:0] status;
	int         fail_count;
	int         outstanding;
	int         results_checked;
	int         flagged_results;

	int         sent = 0;
	int         directed_items = 0;
	int         gap_quiet = 0;
	logic [7:0] recent_keys [$];

	piecewise_linear_rgba_transfer_lut_top uut (.*);

	plrt_transfer_checker lut_check (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// wait length per transaction, with occasional runs of back-to-back traffic
	function automatic int draw_wait(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			quiet = $urandom_range(20, 60);
		return $urandom_range(0, 11);
	endfunction

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [3:0][7:0] pick_color();
		logic [3:0][7:0] c;
		for (int i = 0; i < 4; i++)
			c[i] = pick_channel();
		return c;
	endfunction

	function automatic logic [7:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: if (recent_keys.size() != 0)
				return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
			default: ;
		endcase
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly in range, often right at or next to a stored key
	function automatic logic [7:0] pick_index();
		case ($urandom_range(0, 15))
			0: return 8'd255;
			1, 2, 3, 4, 5: if (recent_keys.size() != 0)
				return recent_keys[$urandom_range(0, recent_keys.size() - 1)]
					+ 8'($urandom_range(0, 2)) - 8'd1;
			default: ;
		endcase
		return 8'($urandom_range(0, 254));
	endfunction

	task automatic drive_request(kind_e op, logic [7:0] value, logic [3:0][7:0] color);
		int gap;
		gap = draw_wait(gap_quiet);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind <= op;
		key_index <= value;
		red_in <= color[0];
		green_in <= color[1];
		blue_in <= color[2];
		alpha_in <= color[3];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sent++;
		if (op == KIND_CLEAR)
			recent_keys.delete();
		else if (op == KIND_INSERT)
			recent_keys.push_back(value);
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int points;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_INSERT;
		key_index = 8'd0;
		red_in = 8'd0;
		green_in = 8'd0;
		blue_in = 8'd0;
		alpha_in = 8'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, out of range index, unused kind
		drive_request(KIND_LOOKUP, 8'd0, 32'h0);
		drive_request(KIND_LOOKUP, 8'd254, 32'h0);
		drive_request(KIND_LOOKUP, 8'd255, 32'hFFFF_FFFF);
		drive_request(KIND_NONE, 8'd255, 32'hFFFF_FFFF);
		// descending keys 255 down to 0 so every insert shifts the whole store
		for (int i = 15; i >= 0; i--)
			drive_request(KIND_INSERT, 8'(i * 17),
				(i % 3 == 0) ? 32'hFFFF_FFFF : (i % 3 == 1) ? 32'h0 : pick_color());
		drive_request(KIND_INSERT, 8'd136, 32'hFFFF_FFFF);
		drive_request(KIND_INSERT, 8'd5, 32'hFFFF_FFFF);
		drive_request(KIND_LOOKUP, 8'd0, 32'h0);
		drive_request(KIND_LOOKUP, 8'd100, 32'h0);
		drive_request(KIND_LOOKUP, 8'd254, 32'h0);
		drive_request(KIND_CLEAR, 8'd255, 32'hFFFF_FFFF);
		drive_request(KIND_LOOKUP, 8'd50, 32'h0);
		directed_items = sent;
		wait_results_drained();

		while (sent < directed_items + RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat (8)
						drive_request(kind_e'($urandom_range(0, 3)), 8'($urandom),
							32'($urandom));
				end
				9: wait_results_drained();
				default: begin
					// build a store, then probe it
					if ($urandom_range(0, 2) != 0)
						drive_request(KIND_CLEAR, 8'($urandom), 32'($urandom));
					points = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 20)
						: $urandom_range(1, 6);
					repeat (points)
						drive_request(KIND_INSERT, pick_key(), pick_color());
					repeat ($urandom_range(3, 20)) begin
						if ($urandom_range(0, 9) == 0)
							drive_request(KIND_INSERT, pick_key(), pick_color());
						else
							drive_request(KIND_LOOKUP, pick_index(), 32'($urandom));
					end
				end
			endcase
		end

		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d transactions driven (%0d directed), %0d results compared", sent,
			directed_items, results_checked);
		$display("%0d results carried a full, duplicate or out-of-range status",
			flagged_results);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// output side stalls per result, keeping ready high across zero-length stalls
	initial begin
		int stall;
		int ready_quiet;
		out_ready = 1'b0;
		ready_quiet = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		stall = draw_wait(ready_quiet);
		forever begin
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			stall = draw_wait(ready_quiet);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("no transaction for %0d cycles, stopping", IDLE_LIMIT);
		$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/plrt_pkg.sv
rtl/plrt_ctrl.sv
rtl/plrt_dpath.sv
rtl/piecewise_linear_rgba_transfer_lut_top.sv
sim/plrt_transfer_checker.sv
sim/tb_piecewise_linear_rgba_transfer_lut_top.sv
